[src/cpe_pkg.sv]
// shared types and constants for the chebyshev polynomial evaluator
package cpe_pkg;

	localparam int MAX_DEGREE = 64;
	localparam int FRAC_BITS  = 30;

	localparam int X_W    = 32;
	localparam int DEG_W  = 7;
	localparam int VAL_W  = 40;
	localparam int PROD_W = X_W + VAL_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int SHIFT  = FRAC_BITS - 1;
	localparam int QUO_W  = ACC_W - SHIFT;
	localparam int CNT_W  = $clog2(MAX_DEGREE + 1);

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

	localparam logic signed [X_W-1:0]   ONE_X   = X_W'(1) << FRAC_BITS;
	localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(1) << FRAC_BITS;
	localparam logic [VAL_W-1:0]        VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0]        VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [DEG_W-1:0]        DEG_MAX = DEG_W'(MAX_DEGREE);

	typedef struct packed {
		logic [X_W-1:0]   x;
		logic [DEG_W-1:0] n;
		logic             kind;
	} job_t;

	typedef struct packed {
		logic [JOBQ_PTR_W:0] count;
		logic                full;
	} front_status_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] steps;
	} back_status_t;

endpackage

[src/cpe_front.sv]
// front end: input clamping and the job queue feeding the recurrence engine
module cpe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [cpe_pkg::X_W-1:0] x_point,
	input  logic [cpe_pkg::DEG_W-1:0]      degree,
	input  logic                           kind,
	output logic                           job_valid,
	output cpe_pkg::job_t                  job,
	input  logic                           job_pop,
	output cpe_pkg::front_status_t         st
);

	cpe_pkg::job_t                   mem_q [cpe_pkg::JOBQ_DEPTH];
	cpe_pkg::job_t                   new_job;
	logic [cpe_pkg::JOBQ_PTR_W-1:0]  wr_ptr_q;
	logic [cpe_pkg::JOBQ_PTR_W-1:0]  rd_ptr_q;
	logic [cpe_pkg::JOBQ_PTR_W:0]    count_q;
	logic                            push_ok;
	logic                            pop_ok;

	// clamp x to [-1,1] and degree to the maximum
	always_comb begin
		if (x_point > cpe_pkg::ONE_X) begin
			new_job.x = cpe_pkg::ONE_X;
		end else if (x_point < -cpe_pkg::ONE_X) begin
			new_job.x = -cpe_pkg::ONE_X;
		end else begin
			new_job.x = x_point;
		end
		new_job.n = (degree > cpe_pkg::DEG_MAX) ? cpe_pkg::DEG_MAX : degree;
		new_job.kind = kind;
	end

	assign full      = (count_q == (cpe_pkg::JOBQ_PTR_W+1)'(cpe_pkg::JOBQ_DEPTH));
	assign job_valid = (count_q != '0);
	assign job       = mem_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = job_pop && job_valid;
	assign st.count  = count_q;
	assign st.full   = full;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == cpe_pkg::JOBQ_PTR_W'(cpe_pkg::JOBQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == cpe_pkg::JOBQ_PTR_W'(cpe_pkg::JOBQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/cpe_back.sv]
// back end: three-term recurrence engine and result register
module cpe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  cpe_pkg::job_t               job,
	output logic                        job_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [cpe_pkg::VAL_W-1:0]   value,
	output logic                        overflow,
	output cpe_pkg::back_status_t       st
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                          state_q;
	logic [cpe_pkg::CNT_W-1:0]           steps_q;
	logic signed [cpe_pkg::X_W-1:0]      x_q;
	logic signed [cpe_pkg::VAL_W-1:0]    prev_q;
	logic signed [cpe_pkg::VAL_W-1:0]    cur_q;
	logic                                ovf_q;
	logic signed [cpe_pkg::PROD_W-1:0]   prod_s1;
	logic                                out_valid_q;
	logic [cpe_pkg::VAL_W-1:0]           out_value_q;
	logic                                out_ovf_q;

	logic [cpe_pkg::VAL_W-1:0]           x_ext;
	logic [cpe_pkg::VAL_W-1:0]           seed;
	logic [cpe_pkg::ACC_W-1:0]           rnd;
	logic [cpe_pkg::ACC_W-1:0]           acc;
	logic [cpe_pkg::QUO_W-1:0]           quo;
	logic                                fits;
	logic [cpe_pkg::VAL_W-1:0]           nxt;
	logic                                load_out;

	// seed of the second term: x, or 2x for the second kind
	assign x_ext = {{(cpe_pkg::VAL_W-cpe_pkg::X_W){job.x[cpe_pkg::X_W-1]}}, job.x};
	assign seed  = job.kind ? (x_ext << 1) : x_ext;

	// round half away from zero folded into one add:
	// floor((p + half - sign(p)) / 2^s) - prev == floor((p + half - sign(p) - prev*2^s) / 2^s)
	assign rnd = (cpe_pkg::ACC_W'(1) << (cpe_pkg::SHIFT - 1))
		- cpe_pkg::ACC_W'(prod_s1[cpe_pkg::PROD_W-1]);
	assign acc = {prod_s1[cpe_pkg::PROD_W-1], prod_s1} + rnd
		- ({{(cpe_pkg::ACC_W-cpe_pkg::VAL_W){prev_q[cpe_pkg::VAL_W-1]}}, prev_q}
		<< cpe_pkg::SHIFT);
	assign quo  = acc[cpe_pkg::ACC_W-1:cpe_pkg::SHIFT];
	assign fits = (&quo[cpe_pkg::QUO_W-1:cpe_pkg::VAL_W-1])
		|| !(|quo[cpe_pkg::QUO_W-1:cpe_pkg::VAL_W-1]);
	assign nxt  = fits ? quo[cpe_pkg::VAL_W-1:0]
		: (quo[cpe_pkg::QUO_W-1] ? cpe_pkg::VAL_MIN : cpe_pkg::VAL_MAX);

	assign job_pop  = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || pop);

	assign empty    = !out_valid_q;
	assign value    = out_value_q;
	assign overflow = out_ovf_q;

	assign st.busy  = (state_q == ST_MUL) || (state_q == ST_ACC);
	assign st.done  = (state_q == ST_DONE);
	assign st.steps = steps_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_s1 <= x_q * cur_q;
		end
		if (load_out) begin
			out_value_q <= cur_q;
			out_ovf_q   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			x_q         <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						x_q    <= job.x;
						prev_q <= cpe_pkg::ONE_V;
						ovf_q  <= 1'b0;
						if (job.n == '0) begin
							cur_q   <= cpe_pkg::ONE_V;
							steps_q <= '0;
							state_q <= ST_DONE;
						end else if (job.n == cpe_pkg::DEG_W'(1)) begin
							cur_q   <= seed;
							steps_q <= '0;
							state_q <= ST_DONE;
						end else begin
							cur_q   <= seed;
							steps_q <= cpe_pkg::CNT_W'(job.n - 1'b1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					prev_q  <= cur_q;
					cur_q   <= nxt;
					ovf_q   <= ovf_q | !fits;
					steps_q <= steps_q - 1'b1;
					state_q <= (steps_q == cpe_pkg::CNT_W'(1)) ? ST_DONE : ST_MUL;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/chebyshev_poly_eval.sv]
// top level of the chebyshev polynomial evaluator
// Evaluates T_N(x) (kind 0) or U_N(x) (kind 1) in signed fixed point with 30 fraction
// bits, by P(k+1) = 2x*P(k) - P(k-1) seeded with 1 and x (or 2x). x is clamped to [-1,1]
// without flagging, a degree above 64 is treated as 64, and every recurrence value is
// saturated to the 40-bit result range; any saturation sets overflow for that result.
// Both sides behave like queues: push while full is low, pop while empty is low. A
// two-entry job queue holds clamped items in front of the engine, so up to two new
// transactions are taken while the engine works and a finished result waits to be
// popped. The engine handles one item at a time: an item of degree N runs max(N-1,0)
// steps of the recurrence loop, and each step passes through the 32x40 multiplier and
// then the round-subtract-saturate adder. Results come out in input order; there is no
// configuration.
module chebyshev_poly_eval (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [cpe_pkg::X_W-1:0] x_point,
	input  logic [cpe_pkg::DEG_W-1:0]      degree,
	input  logic                           kind,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [cpe_pkg::VAL_W-1:0] value,
	output logic                           overflow
);

	// handoff between front and back
	logic                      job_valid;
	cpe_pkg::job_t             job;
	logic                      job_pop;
	cpe_pkg::front_status_t    front_st;
	cpe_pkg::back_status_t     back_st;
	logic [cpe_pkg::VAL_W-1:0] value_raw;

	// front: clamp x and degree, queue the job
	cpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.x_point   (x_point),
		.degree    (degree),
		.kind      (kind),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.st        (front_st)
	);

	// back: run the recurrence and hold the result until popped
	cpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.value     (value_raw),
		.overflow  (overflow),
		.st        (back_st)
	);

	assign value = value_raw;

	// a running recurrence always has steps left to do
	assert property (@(posedge clk) disable iff (!arst_n)
		back_st.busy |-> (back_st.steps != '0))
		else $error("recurrence running with no steps left");

	// a new result only shows up right after the engine finished an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(back_st.done))
		else $error("result appeared without a finished item");

	// job queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		front_st.count <= (cpe_pkg::JOBQ_PTR_W+1)'(cpe_pkg::JOBQ_DEPTH))
		else $error("job queue count beyond depth");

	// the engine only takes a job out of the queue when one is there
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop && !job_valid) |=> !back_st.busy && !back_st.done)
		else $error("engine started without a queued job");

endmodule
